>>> rtl/rpcr_pkg.sv
// Shared constants, types and the quarter-wave sine table for the radar point
// clip and rotate block. No dependencies.
package rpcr_pkg;

    localparam int ANGLE_BITS    = 12;
    localparam int POS_FRAC_BITS = 4;

    localparam int POS_W     = 16;
    localparam int CFG_W     = 10;
    localparam int CAMP_W    = 8;
    localparam int ROM_AW    = ANGLE_BITS - 1;
    localparam int QUARTER   = 1 << (ANGLE_BITS - 2);
    localparam int TRIG_W    = 15;
    localparam int DIFF_W    = POS_W + 1;
    localparam int PROD_W    = DIFF_W + TRIG_W + 1;
    localparam int ROT_W     = PROD_W + 1;
    localparam int Q14       = 14;
    localparam int RND_W     = ROT_W - Q14;
    localparam int CTR_W     = CFG_W + POS_FRAC_BITS;
    localparam int SUM_W     = RND_W + CTR_W + 2;
    localparam int FRAC_MASK = (1 << POS_FRAC_BITS) - 1;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    // configuration register indexes
    localparam logic CFG_WINDOW_HALF_WIDTH = 1'b0;
    localparam logic CFG_RADAR_CENTER      = 1'b1;

    localparam logic [CFG_W-1:0] WINDOW_HALF_WIDTH_RST = 10'd30;
    localparam logic [CFG_W-1:0] RADAR_CENTER_RST      = 10'd60;

    typedef logic [0:QUARTER][TRIG_W-1:0] t_sine_rom;

    // multiply a series term by x squared, all in Q30
    function automatic logic [63:0] taylor_step(
        input logic [63:0] term,
        input logic [63:0] x
    );
        logic [63:0] t;
        t = (term * x) >> 30;
        return (t * x) >> 30;
    endfunction

    // Taylor series of sin in Q30, rounded half up to Q1.14, clamped to one.
    function automatic t_sine_rom sine_table();
        t_sine_rom   rom;
        logic [63:0] x;
        logic [63:0] term;
        longint      sum;
        longint      v;
        rom = '0;
        for (int a = 0; a <= QUARTER; a++) begin
            x    = (64'(a) * PI_HALF_Q30) >> (ANGLE_BITS - 2);
            term = x;
            sum  = longint'(x);
            // each term divides by (2k)(2k+1), signs alternate
            term = taylor_step(term, x) / 64'd6;
            sum  = sum - longint'(term);
            term = taylor_step(term, x) / 64'd20;
            sum  = sum + longint'(term);
            term = taylor_step(term, x) / 64'd42;
            sum  = sum - longint'(term);
            term = taylor_step(term, x) / 64'd72;
            sum  = sum + longint'(term);
            term = taylor_step(term, x) / 64'd110;
            sum  = sum - longint'(term);
            term = taylor_step(term, x) / 64'd156;
            sum  = sum + longint'(term);
            term = taylor_step(term, x) / 64'd210;
            sum  = sum - longint'(term);
            term = taylor_step(term, x) / 64'd272;
            sum  = sum + longint'(term);
            term = taylor_step(term, x) / 64'd342;
            sum  = sum - longint'(term);
            term = taylor_step(term, x) / 64'd420;
            sum  = sum + longint'(term);
            term = taylor_step(term, x) / 64'd506;
            sum  = sum - longint'(term);
            term = taylor_step(term, x) / 64'd600;
            sum  = sum + longint'(term);
            term = taylor_step(term, x) / 64'd702;
            sum  = sum - longint'(term);
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum + 32768) >>> 16;
            if (v > 16384) begin
                v = 16384;
            end
            rom[a] = TRIG_W'(v);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = sine_table();

endpackage

>>> rtl/radar_point_clip_rotate.sv
// Radar point clip and rotate: window test, heading rotation, radar placement.
// Depends on rpcr_pkg (constants and sine table).
//
// One unit point can enter per clock; its result is registered once in each
// stage. Throughput is one point per cycle while the output is not stalled, set by
// the four-stage pipeline (sine and cosine table read, four multipliers,
// rotation sum and rounding, centering and saturation). Each stage has its own
// valid bit and can fill while the output waits, so a stalled output only
// blocks input once all stages hold points. A point outside the square window
// around the viewer, or the viewer itself, yields visible = 0 with all other
// result fields zero. The two configuration registers are written through
// i_cfg_we; write them only while no points are in flight.
module radar_point_clip_rotate (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_index,
    input  logic [rpcr_pkg::CFG_W-1:0]           i_cfg_data,
    // input channel
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [rpcr_pkg::POS_W-1:0]    i_unit_x,
    input  logic signed [rpcr_pkg::POS_W-1:0]    i_unit_y,
    input  logic [rpcr_pkg::CAMP_W-1:0]          i_unit_camp,
    input  logic                                 i_is_self,
    input  logic signed [rpcr_pkg::POS_W-1:0]    i_own_x,
    input  logic signed [rpcr_pkg::POS_W-1:0]    i_own_y,
    input  logic [rpcr_pkg::ANGLE_BITS-1:0]      i_own_heading,
    input  logic [rpcr_pkg::CAMP_W-1:0]          i_own_camp,
    // output channel
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_visible,
    output logic                                 o_friendly,
    output logic signed [rpcr_pkg::POS_W-1:0]    o_radar_x,
    output logic signed [rpcr_pkg::POS_W-1:0]    o_radar_y
);

    localparam int AB = rpcr_pkg::ANGLE_BITS;
    localparam int DW = rpcr_pkg::DIFF_W;

    // truncate Q12.4 toward zero to whole units
    function automatic logic signed [rpcr_pkg::POS_W-1:0] trunc_pos(
        input logic signed [rpcr_pkg::POS_W-1:0] v
    );
        logic signed [DW-1:0] t;
        t = DW'(v);
        if (v < 0) begin
            t = t + DW'(rpcr_pkg::FRAC_MASK);
        end
        t = t >>> rpcr_pkg::POS_FRAC_BITS;
        return rpcr_pkg::POS_W'(t);
    endfunction

    // configuration registers
    logic [rpcr_pkg::CFG_W-1:0] r_window_half_width;
    logic [rpcr_pkg::CFG_W-1:0] r_radar_center;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_half_width <= rpcr_pkg::WINDOW_HALF_WIDTH_RST;
            r_radar_center      <= rpcr_pkg::RADAR_CENTER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rpcr_pkg::CFG_WINDOW_HALF_WIDTH: r_window_half_width <= i_cfg_data;
                rpcr_pkg::CFG_RADAR_CENTER:      r_radar_center      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage valids and per-stage ready chain
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // ---------------- stage 1: offsets, truncated offsets, table read
    logic [AB-1:0]                 cos_angle;
    logic [rpcr_pkg::ROM_AW-1:0]   sin_addr;
    logic [rpcr_pkg::ROM_AW-1:0]   cos_addr;
    logic signed [DW-1:0]          n_dx, n_dy, n_tdx, n_tdy;

    logic signed [DW-1:0]          r1_dx, r1_dy, r1_tdx, r1_tdy;
    logic [rpcr_pkg::TRIG_W-1:0]   r1_sin_mag, r1_cos_mag;
    logic                          r1_sin_neg, r1_cos_neg;
    logic                          r1_self, r1_friendly;

    assign cos_angle = i_own_heading + AB'(rpcr_pkg::QUARTER);

    // odd quadrants read the table mirrored
    always_comb begin
        if (i_own_heading[AB-2]) begin
            sin_addr = rpcr_pkg::ROM_AW'(rpcr_pkg::QUARTER) - {1'b0, i_own_heading[AB-3:0]};
        end else begin
            sin_addr = {1'b0, i_own_heading[AB-3:0]};
        end
        if (cos_angle[AB-2]) begin
            cos_addr = rpcr_pkg::ROM_AW'(rpcr_pkg::QUARTER) - {1'b0, cos_angle[AB-3:0]};
        end else begin
            cos_addr = {1'b0, cos_angle[AB-3:0]};
        end
    end

    assign n_dx  = DW'(i_unit_x) - DW'(i_own_x);
    assign n_dy  = DW'(i_unit_y) - DW'(i_own_y);
    assign n_tdx = DW'(trunc_pos(i_unit_x)) - DW'(trunc_pos(i_own_x));
    assign n_tdy = DW'(trunc_pos(i_unit_y)) - DW'(trunc_pos(i_own_y));

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_dx       <= n_dx;
            r1_dy       <= n_dy;
            r1_tdx      <= n_tdx;
            r1_tdy      <= n_tdy;
            r1_sin_mag  <= rpcr_pkg::SINE_ROM[sin_addr];
            r1_cos_mag  <= rpcr_pkg::SINE_ROM[cos_addr];
            r1_sin_neg  <= i_own_heading[AB-1];
            r1_cos_neg  <= cos_angle[AB-1];
            r1_self     <= i_is_self;
            r1_friendly <= (i_unit_camp == i_own_camp);
        end
    end

    // ---------------- stage 2: window test, products
    logic signed [rpcr_pkg::TRIG_W:0]   sin_val, cos_val;
    logic signed [DW-1:0]               w_pos;
    logic                               n_inside;

    logic signed [rpcr_pkg::PROD_W-1:0] r2_xc, r2_ys, r2_xs, r2_yc;
    logic                               r2_vis, r2_friendly;

    assign sin_val = r1_sin_neg ? -$signed({1'b0, r1_sin_mag}) : $signed({1'b0, r1_sin_mag});
    assign cos_val = r1_cos_neg ? -$signed({1'b0, r1_cos_mag}) : $signed({1'b0, r1_cos_mag});
    assign w_pos   = $signed(DW'(r_window_half_width));

    assign n_inside = (r1_tdx >= -w_pos) && (r1_tdx <= w_pos) &&
                      (r1_tdy >= -w_pos) && (r1_tdy <= w_pos);

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_xc       <= rpcr_pkg::PROD_W'(r1_dx * cos_val);
            r2_ys       <= rpcr_pkg::PROD_W'(r1_dy * sin_val);
            r2_xs       <= rpcr_pkg::PROD_W'(r1_dx * sin_val);
            r2_yc       <= rpcr_pkg::PROD_W'(r1_dy * cos_val);
            r2_vis      <= !r1_self && n_inside;
            r2_friendly <= r1_friendly;
        end
    end

    // ---------------- stage 3: rotation sums, round half up out of Q14
    logic signed [rpcr_pkg::ROT_W-1:0] n_rot_x, n_rot_y;
    logic signed [rpcr_pkg::RND_W-1:0] r3_rx, r3_ry;
    logic                              r3_vis, r3_friendly;

    assign n_rot_x = rpcr_pkg::ROT_W'(r2_xc) - rpcr_pkg::ROT_W'(r2_ys)
                   + rpcr_pkg::ROT_W'(1 << (rpcr_pkg::Q14 - 1));
    assign n_rot_y = rpcr_pkg::ROT_W'(r2_xs) + rpcr_pkg::ROT_W'(r2_yc)
                   + rpcr_pkg::ROT_W'(1 << (rpcr_pkg::Q14 - 1));

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_rx       <= n_rot_x[rpcr_pkg::ROT_W-1:rpcr_pkg::Q14];
            r3_ry       <= n_rot_y[rpcr_pkg::ROT_W-1:rpcr_pkg::Q14];
            r3_vis      <= r2_vis;
            r3_friendly <= r2_friendly;
        end
    end

    // ---------------- stage 4: negate around radar centre, saturate
    localparam int SW = rpcr_pkg::SUM_W;
    localparam logic signed [SW-1:0] POS_MAX = SW'(32767);
    localparam logic signed [SW-1:0] POS_MIN = -SW'(32768);

    logic signed [SW-1:0]            ctr, n_sum_x, n_sum_y;
    logic signed [rpcr_pkg::POS_W-1:0] n_sat_x, n_sat_y;

    logic                              r4_visible, r4_friendly;
    logic signed [rpcr_pkg::POS_W-1:0] r4_radar_x, r4_radar_y;

    assign ctr     = $signed(SW'({r_radar_center, rpcr_pkg::POS_FRAC_BITS'(0)}));
    assign n_sum_x = ctr - SW'(r3_rx);
    assign n_sum_y = ctr - SW'(r3_ry);

    always_comb begin
        if (n_sum_x > POS_MAX) begin
            n_sat_x = rpcr_pkg::POS_W'(POS_MAX);
        end else if (n_sum_x < POS_MIN) begin
            n_sat_x = rpcr_pkg::POS_W'(POS_MIN);
        end else begin
            n_sat_x = rpcr_pkg::POS_W'(n_sum_x);
        end
        if (n_sum_y > POS_MAX) begin
            n_sat_y = rpcr_pkg::POS_W'(POS_MAX);
        end else if (n_sum_y < POS_MIN) begin
            n_sat_y = rpcr_pkg::POS_W'(POS_MIN);
        end else begin
            n_sat_y = rpcr_pkg::POS_W'(n_sum_y);
        end
    end

    // hidden points report all zero
    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_visible  <= r3_vis;
            r4_friendly <= r3_vis && r3_friendly;
            r4_radar_x  <= r3_vis ? n_sat_x : '0;
            r4_radar_y  <= r3_vis ? n_sat_y : '0;
        end
    end

    assign o_visible  = r4_visible;
    assign o_friendly = r4_friendly;
    assign o_radar_x  = r4_radar_x;
    assign o_radar_y  = r4_radar_y;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for radar_point_clip_rotate: window clip, heading rotation and
// radar placement are predicted per point and checked against every output transaction.
// Depends on rpcr_pkg and the radar_point_clip_rotate RTL.
`timescale 1ns / 1ps

typedef struct packed {
    logic signed [rpcr_pkg::POS_W-1:0]   unit_x, unit_y;
    logic [rpcr_pkg::CAMP_W-1:0]         unit_camp;
    logic                                is_self;
    logic signed [rpcr_pkg::POS_W-1:0]   own_x, own_y;
    logic [rpcr_pkg::ANGLE_BITS-1:0]     heading;
    logic [rpcr_pkg::CAMP_W-1:0]         own_camp;
} t_point;

typedef struct packed {
    logic                                visible;
    logic                                friendly;
    logic signed [rpcr_pkg::POS_W-1:0]   x;
    logic signed [rpcr_pkg::POS_W-1:0]   y;
} t_blip;

// Q12.4 position to integer world cell, truncating toward zero.
function automatic int to_cell(int v);
    if (v >= 0) return v >>> rpcr_pkg::POS_FRAC_BITS;
    return -((-v) >>> rpcr_pkg::POS_FRAC_BITS);
endfunction

// Integer cell plus a fraction back to Q12.4, kept inside 16 bits.
function automatic int place(int cell_v, int frac);
    if (cell_v >= 2047) return 32752 + frac;
    if (cell_v <= -2048) return -32768;
    if (cell_v > 0) return cell_v * (1 << rpcr_pkg::POS_FRAC_BITS) + frac;
    if (cell_v < 0) return cell_v * (1 << rpcr_pkg::POS_FRAC_BITS) - frac;
    return ($urandom_range(1) != 0) ? frac : -frac;
endfunction

class blip_predictor;
    int          half_width;
    int          center;
    int          sine_q14 [0:rpcr_pkg::QUARTER];
    t_blip       blips_due [$];
    int          mismatches;

    function new();
        logic [63:0] x;
        logic [63:0] term;
        longint      acc;
        longint      r;
        half_width = 30;
        center     = 60;
        mismatches = 0;
        // quarter-wave sine in Q1.14 from a Q30 Taylor series, rounded half up
        for (int a = 0; a <= rpcr_pkg::QUARTER; a++) begin
            x    = (64'(a) * rpcr_pkg::PI_HALF_Q30) / 64'(rpcr_pkg::QUARTER);
            term = x;
            acc  = longint'(x);
            for (int k = 1; k <= 13; k++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / (64'(2 * k) * 64'(2 * k + 1));
                acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0) acc = 0;
            r = (acc + 32768) / 65536;
            sine_q14[a] = (r > 16384) ? 16384 : int'(r);
        end
    endfunction

    function int trig(int h);
        int q;
        int idx;
        int m;
        q   = (h >> (rpcr_pkg::ANGLE_BITS - 2)) & 3;
        idx = h & (rpcr_pkg::QUARTER - 1);
        m   = (q == 0 || q == 2) ? sine_q14[idx] : sine_q14[rpcr_pkg::QUARTER - idx];
        return (q >= 2) ? -m : m;
    endfunction

    function logic signed [rpcr_pkg::POS_W-1:0] clip16(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return rpcr_pkg::POS_W'(v);
    endfunction

    function void note_point(t_point p);
        int     tox, toy, tux, tuy, h;
        bit     in_window;
        longint dx, dy, s, c, rx, ry, ctr;
        t_blip  b;
        tux = to_cell(p.unit_x);
        tuy = to_cell(p.unit_y);
        tox = to_cell(p.own_x);
        toy = to_cell(p.own_y);
        in_window = tux >= tox - half_width && tux <= tox + half_width &&
                    tuy >= toy - half_width && tuy <= toy + half_width;
        b = '0;
        if (in_window && !p.is_self) begin
            h   = p.heading;
            dx  = longint'(p.unit_x) - longint'(p.own_x);
            dy  = longint'(p.unit_y) - longint'(p.own_y);
            s   = trig(h);
            c   = trig((h + rpcr_pkg::QUARTER) & ((1 << rpcr_pkg::ANGLE_BITS) - 1));
            // round to nearest, ties up: floor of (p + half) / 2^14
            rx  = (dx * c - dy * s + 8192) >>> 14;
            ry  = (dx * s + dy * c + 8192) >>> 14;
            ctr = longint'(center) * (1 << rpcr_pkg::POS_FRAC_BITS);
            b.visible  = 1'b1;
            b.friendly = (p.unit_camp == p.own_camp);
            b.x        = clip16(ctr - rx);
            b.y        = clip16(ctr - ry);
        end
        blips_due = {blips_due, b};
    endfunction

    function void check_blip(t_blip got);
        t_blip want;
        if (blips_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected transaction: vis=%0b fr=%0b x=%0d y=%0d",
                         got.visible, got.friendly, got.x, got.y);
            return;
        end
        want = blips_due.pop_front();
        if (got.visible !== want.visible || got.friendly !== want.friendly ||
            got.x !== want.x || got.y !== want.y) begin
            mismatches++;
            if (mismatches <= 10)
                $display("blip mismatch (vis fr x y): expected %0b %0b %0d %0d, got %0b %0b %0d %0d",
                         want.visible, want.friendly, want.x, want.y,
                         got.visible, got.friendly, got.x, got.y);
        end
    endfunction
endclass

module testbench;

    localparam int LIMIT = 500000;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int PHASE_HW  [PHASES] = '{1023, 1, 0, 30, 200, 5, 1023, 64};
    localparam int PHASE_CTR [PHASES] = '{1023, 0, 512, 60, 0, 1023, 0, 300};
    localparam int SEND_IDLE [4] = '{0, 46, 0, 20};
    localparam int RECV_STALL [4] = '{0, 0, 46, 20};

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic                                i_cfg_index = rpcr_pkg::CFG_WINDOW_HALF_WIDTH;
    logic [rpcr_pkg::CFG_W-1:0]          i_cfg_data = '0;
    logic                                i_valid = 1'b0;
    logic                                o_ready;
    logic signed [rpcr_pkg::POS_W-1:0]   i_unit_x = '0;
    logic signed [rpcr_pkg::POS_W-1:0]   i_unit_y = '0;
    logic [rpcr_pkg::CAMP_W-1:0]         i_unit_camp = '0;
    logic                                i_is_self = 1'b0;
    logic signed [rpcr_pkg::POS_W-1:0]   i_own_x = '0;
    logic signed [rpcr_pkg::POS_W-1:0]   i_own_y = '0;
    logic [rpcr_pkg::ANGLE_BITS-1:0]     i_own_heading = '0;
    logic [rpcr_pkg::CAMP_W-1:0]         i_own_camp = '0;
    logic                                o_valid;
    logic                                i_ready = 1'b0;
    logic                                o_visible;
    logic                                o_friendly;
    logic signed [rpcr_pkg::POS_W-1:0]   o_radar_x;
    logic signed [rpcr_pkg::POS_W-1:0]   o_radar_y;

    blip_predictor book = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;

    radar_point_clip_rotate DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_unit_x      (i_unit_x),
        .i_unit_y      (i_unit_y),
        .i_unit_camp   (i_unit_camp),
        .i_is_self     (i_is_self),
        .i_own_x       (i_own_x),
        .i_own_y       (i_own_y),
        .i_own_heading (i_own_heading),
        .i_own_camp    (i_own_camp),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_visible     (o_visible),
        .o_friendly    (o_friendly),
        .o_radar_x     (o_radar_x),
        .o_radar_y     (o_radar_y)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // check each output transaction, then pick the next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            book.check_blip('{o_visible, o_friendly, o_radar_x, o_radar_y});
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_point pt(int ux, int uy, int ucamp, bit self,
                                  int ox, int oy, int h, int ocamp);
        t_point p;
        p.unit_x    = rpcr_pkg::POS_W'(ux);
        p.unit_y    = rpcr_pkg::POS_W'(uy);
        p.unit_camp = rpcr_pkg::CAMP_W'(ucamp);
        p.is_self   = self;
        p.own_x     = rpcr_pkg::POS_W'(ox);
        p.own_y     = rpcr_pkg::POS_W'(oy);
        p.heading   = rpcr_pkg::ANGLE_BITS'(h);
        p.own_camp  = rpcr_pkg::CAMP_W'(ocamp);
        return p;
    endfunction

    function automatic t_point random_point(int hw);
        t_point p;
        int     pick, span, ux, uy, a, b, tox, toy;
        p.own_x     = rpcr_pkg::POS_W'($urandom);
        p.own_y     = rpcr_pkg::POS_W'($urandom);
        p.own_camp  = rpcr_pkg::CAMP_W'($urandom);
        p.unit_camp = ($urandom_range(1) != 0) ? p.own_camp : rpcr_pkg::CAMP_W'($urandom);
        p.is_self   = ($urandom_range(99) < 8);
        if ($urandom_range(9) == 0)
            p.heading = rpcr_pkg::ANGLE_BITS'($urandom_range(3) * rpcr_pkg::QUARTER
                                              + $urandom_range(2) - 1);
        else
            p.heading = rpcr_pkg::ANGLE_BITS'($urandom);
        tox  = to_cell(p.own_x);
        toy  = to_cell(p.own_y);
        pick = $urandom_range(99);
        if (pick < 65) begin
            // near the viewer: mostly inside the window
            span = (hw + 2) * (1 << rpcr_pkg::POS_FRAC_BITS);
            ux = int'(p.own_x) + int'($urandom_range(2 * span)) - span;
            uy = int'(p.own_y) + int'($urandom_range(2 * span)) - span;
        end else if (pick < 85) begin
            // on the window border or one cell past it
            a = hw + int'($urandom_range(1));
            if ($urandom_range(1) != 0) a = -a;
            b = int'($urandom_range(2 * hw)) - hw;
            if ($urandom_range(1) != 0) begin
                ux = place(tox + a, $urandom_range(rpcr_pkg::FRAC_MASK));
                uy = place(toy + b, $urandom_range(rpcr_pkg::FRAC_MASK));
            end else begin
                ux = place(tox + b, $urandom_range(rpcr_pkg::FRAC_MASK));
                uy = place(toy + a, $urandom_range(rpcr_pkg::FRAC_MASK));
            end
        end else begin
            ux = int'($signed(rpcr_pkg::POS_W'($urandom)));
            uy = int'($signed(rpcr_pkg::POS_W'($urandom)));
        end
        if (ux > 32767) ux = 32767;
        if (ux < -32768) ux = -32768;
        if (uy > 32767) uy = 32767;
        if (uy < -32768) uy = -32768;
        p.unit_x = rpcr_pkg::POS_W'(ux);
        p.unit_y = rpcr_pkg::POS_W'(uy);
        return p;
    endfunction

    task automatic send_point(input t_point p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_unit_x      <= p.unit_x;
        i_unit_y      <= p.unit_y;
        i_unit_camp   <= p.unit_camp;
        i_is_self     <= p.is_self;
        i_own_x       <= p.own_x;
        i_own_y       <= p.own_y;
        i_own_heading <= p.heading;
        i_own_camp    <= p.own_camp;
        do @(posedge i_clk); while (!o_ready);
        book.note_point(p);
    endtask

    // hold off input until every expected blip is out, then let the pipe settle
    task automatic drain();
        i_valid <= 1'b0;
        while (book.blips_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_config(input int hw, input int ctr);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= rpcr_pkg::CFG_WINDOW_HALF_WIDTH;
        i_cfg_data  <= rpcr_pkg::CFG_W'(hw);
        @(posedge i_clk);
        i_cfg_index <= rpcr_pkg::CFG_RADAR_CENTER;
        i_cfg_data  <= rpcr_pkg::CFG_W'(ctr);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        book.half_width = hw;
        book.center     = ctr;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset half width of 30 cells, center 60
        send_point(pt(0, 0, 3, 1, 0, 0, 0, 3));            // viewer itself
        send_point(pt(0, 0, 3, 0, 0, 0, 0, 3));
        send_point(pt(495, 0, 3, 0, 0, 0, 0, 4));          // last cell inside
        send_point(pt(496, 0, 3, 0, 0, 0, 0, 3));          // first cell outside
        send_point(pt(-495, 0, 7, 0, 0, 0, 0, 7));
        send_point(pt(0, -496, 7, 0, 0, 0, 0, 7));
        send_point(pt(-15, 0, 1, 0, 16, 0, 100, 2));       // negative truncation
        send_point(pt(160, -80, 5, 0, 0, 0, 1024, 5));
        send_point(pt(160, -80, 5, 0, 0, 0, 2048, 5));
        send_point(pt(160, -80, 5, 0, 0, 0, 3072, 6));
        send_point(pt(160, -80, 5, 0, 0, 0, 4095, 5));
        send_point(pt(160, -80, 5, 0, 0, 0, 512, 5));
        send_point(pt(-32768, -32768, 255, 0, -32768, -32768, 4095, 0));
        send_point(pt(32767, 32767, 255, 0, 32767, 32767, 1, 255));
        send_point(pt(32767, -32768, 0, 0, -32768, 32767, 0, 0));
        drain();

        // zero half width: only the viewer's own cell
        set_config(0, 0);
        send_point(pt(31, 16, 9, 0, 17, 17, 300, 9));
        send_point(pt(32, 16, 9, 0, 17, 17, 300, 9));
        send_point(pt(-1, -15, 9, 0, 15, 1, 2000, 8));
        drain();

        // widest window and center: drive the rotated sum into saturation
        set_config(1023, 1023);
        send_point(pt(16383, 16383, 2, 0, 0, 0, 2560, 2));
        send_point(pt(16383, -16383, 2, 0, 0, 0, 2560, 1));
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            set_config(PHASE_HW[ph], PHASE_CTR[ph]);
            send_idle_pct  = SEND_IDLE[ph % 4];
            recv_stall_pct = RECV_STALL[ph % 4];
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(199) == 0) drain();
                send_point(random_point(PHASE_HW[ph]));
            end
            drain();
        end

        if (book.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/rpcr_pkg.sv
rtl/radar_point_clip_rotate.sv
tb/testbench.sv
